>>> sv/alarm_list_second_timer_assert.svh
// assertion macros for the alarm list timer checker
`ifndef ALARM_LIST_SECOND_TIMER_ASSERT_SVH
`define ALARM_LIST_SECOND_TIMER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define ALST_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("alarm timer stream property violated");

// next-cycle implication, sampled on clk, off during reset
`define ALST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("alarm timer stream property violated");

`endif

>>> sv/alst_pkg.sv
// types and constants of the alarm list second timer
package alst_pkg;

    // operation codes carried in the input tuser
    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_ADD    = 3'd1,
        OP_REMOVE = 3'd2,
        OP_SET    = 3'd3,
        OP_START  = 3'd4,
        OP_PAUSE  = 3'd5,
        OP_RESET  = 3'd6
    } op_t;

    // result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_NOT_OCC = 2'd2;

    // input tdata layout
    localparam int IN_TDATA_W = 64;
    localparam int IN_TAG_LSB = 0;
    localparam int IN_DLY_LSB = 8;
    localparam int IN_POS_LSB = 24;
    localparam int IN_NT_LSB  = 28;

    // output tdata layout, count field follows the time field
    localparam int OUT_TAG_LSB  = 0;
    localparam int OUT_TIME_LSB = 8;
    localparam int OUT_CNT_LSB  = 40;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    // one table entry
    typedef struct packed {
        logic [31:0] due_time;
        logic [7:0]  tag;
    } entry_t;

    // per-cell control: load from broadcast bus, or take the right neighbor
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

>>> sv/alarm_list_second_timer.sv
// alarm list second timer: seconds counter with an ordered row of alarm cells
// commands give their single result transfer via the finish state and the output register
// a running tick walks the table head once per entry, plus output stalls
// one item at a time; the row scan takes one entry per cycle unless a fire waits on output
// reset: time 0, paused, table empty; entries hold garbage but are never read
module alarm_list_second_timer #(
    parameter int ALARM_SLOTS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // input stream
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // alarm_tag, delay_seconds, position, new_time, zero pad
    input  logic [alst_pkg::IN_TDATA_W-1:0]         s_axis_tdata,
    // operation
    input  logic [2:0]                              s_axis_tuser,
    // result stream
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // fired_tag, current_time, alarm_count, status, zero pad
    output logic [((43+$clog2(ALARM_SLOTS+1)+7)/8)*8-1:0] m_axis_tdata,
    // fired
    output logic                                    m_axis_tuser,
    output logic                                    m_axis_tlast
);
    import alst_pkg::*;

    localparam int CW     = $clog2(ALARM_SLOTS + 1);
    localparam int CMPW   = (CW > 4) ? CW : 4;
    localparam int ST_LSB = OUT_CNT_LSB + CW;

    // input field split
    op_t         in_op;
    logic [7:0]  in_tag;
    logic [15:0] in_delay;
    logic [3:0]  in_pos;
    logic [31:0] in_new_time;

    assign in_op       = op_t'(s_axis_tuser);
    assign in_tag      = s_axis_tdata[IN_TAG_LSB +: 8];
    assign in_delay    = s_axis_tdata[IN_DLY_LSB +: 16];
    assign in_pos      = s_axis_tdata[IN_POS_LSB +: 4];
    assign in_new_time = s_axis_tdata[IN_NT_LSB +: 32];

    // control and state registers
    state_t          state_reg,      state_next;
    logic [31:0]     time_reg,       time_next;
    logic            running_reg,    running_next;
    logic [CW-1:0]   count_reg,      count_next;
    logic [CW-1:0]   steps_reg,      steps_next;
    logic [1:0]      status_reg,     status_next;
    // a fired alarm held back until we know whether it is the final transfer
    logic            pend_valid_reg, pend_valid_next;
    logic [7:0]      pend_tag_reg,   pend_tag_next;
    logic [CW-1:0]   pend_count_reg, pend_count_next;

    // output register
    logic            out_valid_reg,  out_valid_next;
    logic            out_fired_reg;
    logic [7:0]      out_tag_reg;
    logic [31:0]     out_time_reg;
    logic [CW-1:0]   out_count_reg;
    logic [1:0]      out_status_reg;
    logic            out_last_reg;

    // emit request toward the output register
    logic            emit;
    logic            emit_fired;
    logic [7:0]      emit_tag;
    logic [CW-1:0]   emit_count;
    logic [1:0]      emit_status;
    logic            emit_last;

    logic            s_accept;
    logic            out_free;

    // cell row controls
    logic            do_add;
    logic            do_remove;
    logic            scan_shift;
    logic            scan_rotate;
    logic            head_match;
    entry_t          bus;
    entry_t          cell_q [ALARM_SLOTS];
    cell_ctrl_t      cell_ctrl [ALARM_SLOTS];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // head entry is compared against the already advanced time
    assign head_match = (cell_q[0].due_time == time_reg);

    // during a scan the head rotates to the tail; otherwise the bus carries a new alarm
    always_comb
    begin
        if (state_reg == ST_SCAN)
        begin
            bus = cell_q[0];
        end
        else
        begin
            bus.due_time = time_reg + 32'(in_delay);
            bus.tag      = in_tag;
        end
    end

    // the cell row: each cell loads from the bus or takes its right neighbor
    for (genvar i = 0; i < ALARM_SLOTS; i++)
    begin : g_cell
        logic   add_sel;
        logic   rm_sel;
        logic   rot_sel;
        entry_t nbr;

        // add writes the first free slot, rotation writes the last occupied one
        assign add_sel = (count_reg == CW'(i));
        assign rot_sel = (count_reg == CW'(i + 1));
        // remove closes the gap from the removed position upward
        assign rm_sel  = (CMPW'(i) >= CMPW'(in_pos));

        assign cell_ctrl[i].load  = (do_add && add_sel) || (scan_rotate && rot_sel);
        assign cell_ctrl[i].shift = (do_remove && rm_sel) || scan_shift;

        if (i == ALARM_SLOTS - 1)
        begin : g_tail
            assign nbr = cell_q[i];
        end
        else
        begin : g_mid
            assign nbr = cell_q[i + 1];
        end

        alst_cell u_cell (
            .clk  (clk),
            .ctrl (cell_ctrl[i]),
            .bus  (bus),
            .nbr  (nbr),
            .q    (cell_q[i])
        );
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        time_next       = time_reg;
        running_next    = running_reg;
        count_next      = count_reg;
        steps_next      = steps_reg;
        status_next     = status_reg;
        pend_valid_next = pend_valid_reg;
        pend_tag_next   = pend_tag_reg;
        pend_count_next = pend_count_reg;

        do_add      = 1'b0;
        do_remove   = 1'b0;
        scan_shift  = 1'b0;
        scan_rotate = 1'b0;

        emit        = 1'b0;
        emit_fired  = 1'b0;
        emit_tag    = 8'd0;
        emit_count  = count_reg;
        emit_status = STATUS_OK;
        emit_last   = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    status_next     = STATUS_OK;
                    pend_valid_next = 1'b0;
                    state_next      = ST_FIN;
                    case (in_op)
                        OP_TICK:
                        begin
                            if (running_reg)
                            begin
                                time_next  = time_reg + 32'd1;
                                steps_next = count_reg;
                                state_next = ST_SCAN;
                            end
                        end
                        OP_ADD:
                        begin
                            if (count_reg == CW'(ALARM_SLOTS))
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                do_add     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (CMPW'(in_pos) >= CMPW'(count_reg))
                            begin
                                status_next = STATUS_NOT_OCC;
                            end
                            else
                            begin
                                do_remove  = 1'b1;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        OP_SET:
                        begin
                            time_next = in_new_time;
                        end
                        OP_START:
                        begin
                            running_next = 1'b1;
                        end
                        OP_PAUSE:
                        begin
                            running_next = 1'b0;
                        end
                        OP_RESET:
                        begin
                            running_next = 1'b0;
                            count_next   = '0;
                            time_next    = 32'd0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (steps_reg == '0)
                begin
                    // every original entry seen: flush the held fire or a plain result
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        emit_fired = pend_valid_reg;
                        emit_tag   = pend_valid_reg ? pend_tag_reg : 8'd0;
                        state_next = ST_IDLE;
                    end
                end
                else if (head_match)
                begin
                    // a new fire pushes out the held one as a non-final transfer
                    if (!pend_valid_reg || out_free)
                    begin
                        emit            = pend_valid_reg;
                        emit_fired      = 1'b1;
                        emit_tag        = pend_tag_reg;
                        emit_count      = pend_count_reg;
                        emit_last       = 1'b0;
                        scan_shift      = 1'b1;
                        count_next      = count_reg - CW'(1);
                        pend_valid_next = 1'b1;
                        pend_tag_next   = cell_q[0].tag;
                        pend_count_next = count_reg - CW'(1);
                        steps_next      = steps_reg - CW'(1);
                    end
                end
                else
                begin
                    // not due: move the head to the tail, order is kept
                    scan_shift  = 1'b1;
                    scan_rotate = 1'b1;
                    steps_next  = steps_reg - CW'(1);
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    emit_status = status_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = emit || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            time_reg       <= 32'd0;
            running_reg    <= 1'b0;
            count_reg      <= '0;
            steps_reg      <= '0;
            status_reg     <= STATUS_OK;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            time_reg       <= time_next;
            running_reg    <= running_next;
            count_reg      <= count_next;
            steps_reg      <= steps_next;
            status_reg     <= status_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        pend_tag_reg   <= pend_tag_next;
        pend_count_reg <= pend_count_next;
        if (emit)
        begin
            out_fired_reg  <= emit_fired;
            out_tag_reg    <= emit_tag;
            out_time_reg   <= time_reg;
            out_count_reg  <= emit_count;
            out_status_reg <= emit_status;
            out_last_reg   <= emit_last;
        end
    end

    // result packing
    always_comb
    begin
        m_axis_tdata                       = '0;
        m_axis_tdata[OUT_TAG_LSB +: 8]     = out_tag_reg;
        m_axis_tdata[OUT_TIME_LSB +: 32]   = out_time_reg;
        m_axis_tdata[OUT_CNT_LSB +: CW]    = out_count_reg;
        m_axis_tdata[ST_LSB +: 2]          = out_status_reg;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_fired_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

>>> sv/alst_cell.sv
// one alarm table cell: holds an entry, loads from the bus or its right neighbor
module alst_cell (
    input  logic                clk,
    input  alst_pkg::cell_ctrl_t ctrl,
    input  alst_pkg::entry_t    bus,
    input  alst_pkg::entry_t    nbr,
    output alst_pkg::entry_t    q
);
    import alst_pkg::*;

    entry_t q_reg;
    entry_t q_next;

    always_comb
    begin
        q_next = q_reg;
        if (ctrl.load)
        begin
            q_next = bus;
        end
        else if (ctrl.shift)
        begin
            q_next = nbr;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

>>> sv/alst_checker.sv
// port-level checker for the alarm list second timer, bound to the top level
`include "alarm_list_second_timer_assert.svh"

module alst_checker #(
    parameter int ALARM_SLOTS = 16
) (
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    s_axis_tvalid,
    input logic                                    s_axis_tready,
    input logic                                    m_axis_tvalid,
    input logic                                    m_axis_tready,
    input logic [((43+$clog2(ALARM_SLOTS+1)+7)/8)*8-1:0] m_axis_tdata,
    input logic                                    m_axis_tuser,
    input logic                                    m_axis_tlast
);
    import alst_pkg::*;

    localparam int CW     = $clog2(ALARM_SLOTS + 1);
    localparam int ST_LSB = OUT_CNT_LSB + CW;

    logic [1:0] res_status;
    logic [7:0] res_tag;

    assign res_status = m_axis_tdata[ST_LSB +: 2];
    assign res_tag    = m_axis_tdata[OUT_TAG_LSB +: 8];

    // one item at a time: an accepted transfer closes the input
    `ALST_ASSERT_NEXT(a_in_single, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // a stalled result stays offered
    `ALST_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    // only fired alarms can be followed by more transfers of the same item
    `ALST_ASSERT_IMP(a_nonlast_fired, m_axis_tvalid && !m_axis_tlast, m_axis_tuser)
    // a result with no fire carries a zero tag
    `ALST_ASSERT_IMP(a_tag_zero, m_axis_tvalid && !m_axis_tuser, res_tag == 8'd0)
    // fired alarms always report ok status
    `ALST_ASSERT_IMP(a_fire_ok, m_axis_tvalid && m_axis_tuser, res_status == STATUS_OK)

endmodule

bind alarm_list_second_timer alst_checker #(.ALARM_SLOTS(ALARM_SLOTS)) u_alst_checker (.*);

>>> tb/sv/alarm_list_second_timer_tb.sv
// self-checking stream testbench for the alarm list second timer
module alarm_list_second_timer_tb;
    import alst_pkg::*;

    localparam int ALARM_SLOTS = 16;
    // width of the alarm count field and of the whole result word
    localparam int CNT_W = $clog2(ALARM_SLOTS + 1);
    localparam int OUT_W = ((43 + CNT_W + 7) / 8) * 8;
    localparam int STATUS_LSB = OUT_CNT_LSB + CNT_W;

    // code outside the defined operations, the block must ignore it
    localparam logic [2:0] OP_UNDEFINED = 3'd7;

    // run shaping
    localparam int RANDOM_ITEMS   = 70;
    localparam int LONG_HOLD      = 400;   // receiver hold-off under pressure
    localparam int END_TAIL       = ALARM_SLOTS + 8;
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no transfer on either side

    // random stimulus is built from short sequences of these kinds
    typedef enum int {
        SEQ_ALARMS,
        SEQ_WRAP,
        SEQ_NOISE,
        SEQ_PAUSE,
        SEQ_RESET,
        SEQ_BAD_REMOVE,
        SEQ_FILL
    } seq_kind_t;

    // one expected result transfer
    typedef struct {
        logic             fired;
        logic [7:0]       tag;
        logic [31:0]      now;
        logic [CNT_W-1:0] count;
        logic [1:0]       status;
        logic             is_last;
    } alarm_result_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata;
    logic [2:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    // timer state as the testbench expects it
    logic [31:0] mdl_time;
    bit          mdl_running;
    int          mdl_count;
    logic [31:0] mdl_due [ALARM_SLOTS];
    logic [7:0]  mdl_tag [ALARM_SLOTS];

    // results predicted but not yet seen, oldest first
    alarm_result_t pending_results[$];

    // bookkeeping
    int  mismatches    = 0;
    int  items_sent    = 0;
    int  results_seen  = 0;
    int  fires_seen    = 0;
    int  full_seen     = 0;
    int  notocc_seen   = 0;
    int  stall_cycles  = 0;
    int  rx_hold_cycles = 0;  // set by a test, consumed by the receiver
    bit  burst_mode    = 1'b0; // no idling on either side while set

    alarm_list_second_timer #(
        .ALARM_SLOTS (ALARM_SLOTS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 20 unit clock period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (burst_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ---------------------------------------------------------------
    // timer prediction
    // ---------------------------------------------------------------

    // queue one expected result
    task automatic push_result(input logic fired, input logic [7:0] tag,
                               input logic [1:0] status);
        alarm_result_t r;
        r.fired   = fired;
        r.tag     = tag;
        r.now     = mdl_time;
        r.count   = mdl_count[CNT_W-1:0];
        r.status  = status;
        r.is_last = 1'b0;
        pending_results.push_back(r);
    endtask

    // take one entry out of the table, later entries move up
    task automatic drop_alarm(input int slot);
        for (int j = slot; j + 1 < mdl_count; j++)
        begin
            mdl_due[j] = mdl_due[j + 1];
            mdl_tag[j] = mdl_tag[j + 1];
        end
        mdl_count--;
    endtask

    // apply one accepted operation and queue the results it causes
    task automatic predict_timer_op(input logic [2:0] op, input logic [7:0] tag,
                                    input logic [15:0] delay, input logic [3:0] pos,
                                    input logic [31:0] nt);
        int         produced;
        int         i;
        logic [1:0] status;
        logic [7:0] ftag;
        produced = 0;
        status   = STATUS_OK;
        case (op)
            OP_TICK:
                if (mdl_running)
                begin
                    mdl_time = mdl_time + 32'd1;
                    i = 0;
                    // every alarm due at the new time fires, in table order
                    while (i < mdl_count)
                    begin
                        if (mdl_due[i] == mdl_time)
                        begin
                            ftag = mdl_tag[i];
                            drop_alarm(i);
                            push_result(1'b1, ftag, STATUS_OK);
                            produced++;
                        end
                        else
                            i++;
                    end
                end
            OP_ADD:
                if (mdl_count >= ALARM_SLOTS)
                    status = STATUS_FULL;
                else
                begin
                    mdl_due[mdl_count] = mdl_time + {16'd0, delay};
                    mdl_tag[mdl_count] = tag;
                    mdl_count++;
                end
            OP_REMOVE:
                if (int'(pos) >= mdl_count)
                    status = STATUS_NOT_OCC;
                else
                    drop_alarm(int'(pos));
            OP_SET:
                mdl_time = nt;
            OP_START:
                mdl_running = 1'b1;
            OP_PAUSE:
                mdl_running = 1'b0;
            OP_RESET:
            begin
                mdl_running = 1'b0;
                mdl_count   = 0;
                mdl_time    = 32'd0;
            end
            default:
                ;
        endcase
        if (produced == 0)
            push_result(1'b0, 8'h00, status);
        pending_results[pending_results.size() - 1].is_last = 1'b1;
    endtask

    // ---------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------

    // offer one item after a random gap, return at the edge it is accepted
    task automatic send_op(input logic [2:0] op, input logic [7:0] tag,
                           input logic [15:0] delay, input logic [3:0] pos,
                           input logic [31:0] nt);
        logic [IN_TDATA_W-1:0] word;
        int                    gap;
        word = '0;
        word[IN_TAG_LSB +: 8]  = tag;
        word[IN_DLY_LSB +: 16] = delay;
        word[IN_POS_LSB +: 4]  = pos;
        word[IN_NT_LSB +: 32]  = nt;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_timer_op(op, tag, delay, pos, nt);
        // ignored codes do not count as stimulus
        if (op != OP_UNDEFINED)
            items_sent++;
    endtask

    // operation whose other fields are don't-care, filled with noise
    task automatic send_cmd(input logic [2:0] op);
        send_op(op, 8'($urandom()), 16'($urandom()), 4'($urandom()), $urandom());
    endtask

    task automatic send_add(input logic [7:0] tag, input logic [15:0] delay);
        send_op(OP_ADD, tag, delay, 4'($urandom()), $urandom());
    endtask

    task automatic send_remove(input logic [3:0] pos);
        send_op(OP_REMOVE, 8'($urandom()), 16'($urandom()), pos, $urandom());
    endtask

    task automatic send_set(input logic [31:0] nt);
        send_op(OP_SET, 8'($urandom()), 16'($urandom()), 4'($urandom()), nt);
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // receiver side: random stalls, plus one long hold-off on request
    // ---------------------------------------------------------------
    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles > 0)
            begin
                // long hold-off, counted here so the sender keeps going
                m_axis_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
            end
            else
            begin
                gap = pick_gap();
                if (gap == 0)
                    m_axis_tready <= 1'b1;
                else
                begin
                    m_axis_tready <= 1'b0;
                    repeat (gap - 1) @(posedge clk);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------
    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // every result transfer is held against the oldest prediction
    always @(posedge clk)
    begin : result_check
        alarm_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no prediction waiting: tdata 0x%0h",
                       m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("fired", 64'(want.fired), 64'(m_axis_tuser));
                check_field("fired_tag", 64'(want.tag),
                            64'(m_axis_tdata[OUT_TAG_LSB +: 8]));
                check_field("current_time", 64'(want.now),
                            64'(m_axis_tdata[OUT_TIME_LSB +: 32]));
                check_field("alarm_count", 64'(want.count),
                            64'(m_axis_tdata[OUT_CNT_LSB +: CNT_W]));
                check_field("status", 64'(want.status),
                            64'(m_axis_tdata[STATUS_LSB +: 2]));
                check_field("last", 64'(want.is_last), 64'(m_axis_tlast));
                if (want.fired)
                    fires_seen++;
                if (want.status == STATUS_FULL)
                    full_seen++;
                if (want.status == STATUS_NOT_OCC)
                    notocc_seen++;
            end
        end
    end

    // watchdog: too long without any transfer ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("[alarm_list_second_timer] ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // directed: field extremes, every operation and the corner cases
    task automatic test_directed();
        send_cmd(OP_TICK);                  // tick while paused, time stays 0
        send_op(OP_UNDEFINED, 8'hFF, 16'hFFFF, 4'hF, 32'hFFFF_FFFF);
        send_cmd(OP_START);
        send_cmd(OP_START);                 // start while running
        send_cmd(OP_TICK);                  // time 1, nothing due
        send_add(8'hFF, 16'hFFFF);
        send_add(8'h00, 16'h0000);          // due now, fires only after a wrap
        send_add(8'hA5, 16'd2);
        send_add(8'h5A, 16'd2);             // same due time as the one before
        send_add(8'h3C, 16'd1);
        send_remove(4'hF);                  // unoccupied position
        send_remove(4'h0);                  // head removal closes the gap
        send_cmd(OP_TICK);                  // one alarm fires
        send_cmd(OP_TICK);                  // two alarms fire on one tick
        send_set(32'hFFFF_FFFF);
        send_cmd(OP_TICK);                  // time wraps to 0
        send_cmd(OP_TICK);                  // zero-delay alarm fires at 1
        send_set(32'h0000_0000);
        send_cmd(OP_PAUSE);
        send_cmd(OP_TICK);                  // paused again
        send_add(8'h11, 16'd3);
        send_cmd(OP_RESET);                 // clears table, time and run flag
        send_cmd(OP_TICK);
        wait_drained();
    endtask

    // fill the table behind a long receiver hold-off so the input stalls,
    // then one tick fires every slot at once
    task automatic test_receiver_backpressure();
        int d;
        d = $urandom_range(1, 3);
        rx_hold_cycles = LONG_HOLD;
        send_cmd(OP_RESET);
        send_set($urandom());
        send_cmd(OP_START);
        for (int k = 0; k < ALARM_SLOTS; k++)
            send_add(8'($urandom()), 16'(d));
        send_add(8'($urandom()), 16'($urandom()));   // table full, rejected
        repeat (d + 2) send_cmd(OP_TICK);
        // sender waits here for every result before moving on
        wait_drained();
    endtask

    // mostly well-formed alarm sequences with random content, some noise
    task automatic test_random_sequences();
        int        stop_at;
        int        r;
        int        n;
        int        d;
        int        limit;
        seq_kind_t kind;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)       kind = SEQ_ALARMS;
            else if (r < 57)  kind = SEQ_WRAP;
            else if (r < 71)  kind = SEQ_NOISE;
            else if (r < 80)  kind = SEQ_PAUSE;
            else if (r < 87)  kind = SEQ_RESET;
            else if (r < 95)  kind = SEQ_BAD_REMOVE;
            else              kind = SEQ_FILL;
            // some sequences run with no idling at all
            burst_mode = ($urandom_range(0, 3) == 0);
            case (kind)
                SEQ_ALARMS:
                begin
                    if (!mdl_running)
                        send_cmd(OP_START);
                    n = $urandom_range(1, 4);
                    d = $urandom_range(1, 4);
                    for (int k = 0; k < n; k++)
                    begin
                        // often share the due time so several fire together
                        if ($urandom_range(0, 2) == 0)
                            d = $urandom_range(1, 4);
                        send_add(8'($urandom()), 16'(d));
                    end
                    if ($urandom_range(0, 3) == 0)
                    begin
                        limit = (mdl_count < 15) ? mdl_count : 15;
                        send_remove(4'($urandom_range(0, limit)));
                    end
                    repeat ($urandom_range(1, 5)) send_cmd(OP_TICK);
                end
                SEQ_WRAP:
                begin
                    // due times that straddle the 32-bit wrap
                    send_set(32'hFFFF_FFFF - $urandom_range(0, 3));
                    repeat ($urandom_range(1, 3))
                        send_add(8'($urandom()), 16'($urandom_range(1, 6)));
                    send_cmd(OP_START);
                    repeat ($urandom_range(2, 7)) send_cmd(OP_TICK);
                end
                SEQ_NOISE:
                    repeat (3)
                        send_op(3'($urandom_range(0, 7)), 8'($urandom()),
                                16'($urandom()), 4'($urandom()), $urandom());
                SEQ_PAUSE:
                begin
                    send_cmd(OP_PAUSE);
                    repeat ($urandom_range(1, 2)) send_cmd(OP_TICK);
                    send_cmd(OP_START);
                end
                SEQ_RESET:
                    send_cmd(OP_RESET);
                SEQ_BAD_REMOVE:
                    send_remove(4'($urandom()));
                SEQ_FILL:
                begin
                    send_cmd(OP_RESET);
                    send_set($urandom());
                    send_cmd(OP_START);
                    d = $urandom_range(1, 3);
                    for (int k = 0; k < ALARM_SLOTS; k++)
                        send_add(8'($urandom()), 16'(d));
                    send_add(8'($urandom()), 16'($urandom()));
                    repeat (d) send_cmd(OP_TICK);
                end
                default:
                    ;
            endcase
        end
        burst_mode = 1'b0;
        wait_drained();
    endtask

    // ---------------------------------------------------------------
    // run control
    // ---------------------------------------------------------------
    initial
    begin
        // all block inputs known from time zero
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_TICK;
        mdl_time      = 32'd0;
        mdl_running   = 1'b0;
        mdl_count     = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_receiver_backpressure();
        test_random_sequences();

        // let any stray transfer show up before the verdict
        repeat (END_TAIL) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d predicted results never arrived", pending_results.size());
            mismatches++;
        end

        $display("covered %0d operations and %0d result transfers, %0d of them alarm firings",
                 items_sent, results_seen, fires_seen);
        $display("table-full rejections %0d, removals at empty positions %0d",
                 full_seen, notocc_seen);
        if (mismatches == 0)
            $display("[alarm_list_second_timer] OK");
        else
            $display("[alarm_list_second_timer] ERROR");
        $finish;
    end

endmodule
